FILE: rtl/core/dihp_pkg.sv
`default_nettype none

package dihp_pkg;

	// Header geometry.
	localparam int TRACK_ENTRIES = 164;
	localparam int NAME_BYTES    = 26;
	localparam int HEADER_FIXED  = NAME_BYTES + 6;
	localparam int HEADER_MIN    = HEADER_FIXED + 4 * TRACK_ENTRIES;

	localparam int POS_W    = $clog2(HEADER_MIN + 1);
	localparam int TRK_W    = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0]  PROTECT_ON     = 8'h10;
	localparam logic [7:0]  PROTECT_OFF    = 8'h00;
	localparam logic [31:0] SHORTEN_BYTES  = 32'd16;
	localparam logic [7:0]  SHORTEN_TRACKS = 8'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_A   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_B   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_C   = 2'd3;

	// Result kinds.
	localparam logic [2:0] KIND_TRACK       = 3'd0;
	localparam logic [2:0] KIND_ACCEPTED    = 3'd1;
	localparam logic [2:0] KIND_NAME_UNTERM = 3'd2;
	localparam logic [2:0] KIND_BAD_PROTECT = 3'd3;
	localparam logic [2:0] KIND_BAD_TYPE    = 3'd4;
	localparam logic [2:0] KIND_BAD_SIZE    = 3'd5;
	localparam logic [2:0] KIND_BAD_OFFSET  = 3'd6;

	// Depth of the result queue; a power of two.
	localparam int RQ_DEPTH = 8;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

	typedef struct packed {
		logic [2:0]       kind;
		logic [TRK_W-1:0] track_index;
		logic [31:0]      track_size;
		logic             write_protected;
		logic [7:0]       disk_type;
		logic [31:0]      disk_size;
		logic             last;
	} result_t;

	// Results produced by one header byte: zero, one or two words.
	typedef struct packed {
		logic [1:0] count;
		result_t    rec0;
		result_t    rec1;
	} push_t;

endpackage

`default_nettype wire

FILE: rtl/core/disk_image_header_parser_unit.sv
`default_nettype none

// Floppy disk image header parser.
//
// The byte channel (byte_valid, byte_stall, data_byte, first_byte) carries
// one header byte per word; a word with first_byte set starts a new image.
// The result channel (result_valid, result_stall and the result fields)
// carries track size words, then one closing word: header accepted or an
// error code. One byte can produce up to two result words.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data; the user must do so only while the block is idle (not enforced).
// A byte accepted into the input register is parsed combinationally from
// there, and its results are then written into the result queue, whose
// count drives result_valid.
// Throughput: one byte per cycle while byte_stall is low. The byte is
// parsed in a single pass of compare and subtract logic after its input
// register. Results go through an eight-word queue; byte_stall rises when
// fewer than four queue slots would remain free, which only happens while
// the receiver stalls. Reset clears the parse and waits for a byte marked
// first_byte; the configuration registers return to their default values.
// Bytes arriving with no parse under way are dropped without a result.
module disk_image_header_parser_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_write,
	input  wire [1:0]  cfg_index,
	input  wire [31:0] cfg_data,
	input  wire        byte_valid,
	output logic       byte_stall,
	input  wire [7:0]  data_byte,
	input  wire        first_byte,
	output logic       result_valid,
	input  wire        result_stall,
	output logic [2:0] kind,
	output logic [7:0] track_index,
	output logic [31:0] track_size,
	output logic       write_protected,
	output logic [7:0] disk_type,
	output logic [31:0] disk_size,
	output logic       last
);
	import dihp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       room;
	push_t      push;
	result_t    head;

	// Input register: a byte is taken whenever the queue has room.
	assign byte_stall = !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= byte_valid && !byte_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	dihp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.first_s1  (first_s1),
		.push      (push)
	);

	dihp_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head)
	);

	assign kind            = head.kind;
	assign track_index     = head.track_index;
	assign track_size      = head.track_size;
	assign write_protected = head.write_protected;
	assign disk_type       = head.disk_type;
	assign disk_size       = head.disk_size;
	assign last            = head.last;

endmodule

`default_nettype wire

FILE: rtl/core/dihp_parse.sv
`default_nettype none

module dihp_parse (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_write,
	input  wire [dihp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [31:0]                        cfg_data,
	input  wire                               valid_s1,
	input  wire [7:0]                         data_s1,
	input  wire                               first_s1,
	output dihp_pkg::push_t                   push
);
	import dihp_pkg::*;

	localparam logic [POS_W-1:0] NAME_LAST_POS = POS_W'(NAME_BYTES - 1);
	localparam logic [POS_W-1:0] PROTECT_POS   = POS_W'(NAME_BYTES);
	localparam logic [POS_W-1:0] TYPE_POS      = POS_W'(NAME_BYTES + 1);
	localparam logic [POS_W-1:0] FIXED_POS     = POS_W'(HEADER_FIXED);
	localparam logic [POS_W-1:0] SIZE_LAST_POS = POS_W'(HEADER_FIXED - 1);
	localparam logic [31:0]      MIN_SIZE      = 32'(HEADER_MIN);
	localparam logic [TRK_W-1:0] ENTRIES_INIT  = TRK_W'(TRACK_ENTRIES);
	localparam logic [TRK_W-1:0] TRK_LAST      = TRK_W'(TRACK_ENTRIES - 1);

	// Configuration registers.
	logic [31:0] max_size_q;
	logic [7:0]  type_a_q, type_b_q, type_c_q;

	// Parse state.
	logic [POS_W-1:0] pos_q, pos_d;
	logic             name_term_q, name_term_d;
	logic             finished_q, finished_d;
	logic [31:0]      gather_q, gather_d;
	logic [31:0]      size_q, size_d;
	logic [31:0]      rmin_q, rmin_d;
	logic [TRK_W-1:0] prev_trk_q, prev_trk_d;
	logic             prev_valid_q, prev_valid_d;
	logic [TRK_W-1:0] entries_q, entries_d;
	logic             protect_q, protect_d;
	logic [7:0]       type_q, type_d;

	// State as seen by the current byte: a first byte sees a cleared parse.
	logic [POS_W-1:0] cur_pos;
	logic             cur_name_term;
	logic [31:0]      cur_gather, cur_size, cur_rmin;
	logic [TRK_W-1:0] cur_prev_trk, cur_entries;
	logic             cur_prev_valid, cur_protect;
	logic [7:0]       cur_type;

	assign cur_pos        = first_s1 ? '0 : pos_q;
	assign cur_name_term  = first_s1 ? 1'b0 : name_term_q;
	assign cur_gather     = first_s1 ? '0 : gather_q;
	assign cur_size       = first_s1 ? '0 : size_q;
	assign cur_rmin       = first_s1 ? MIN_SIZE : rmin_q;
	assign cur_prev_trk   = first_s1 ? '0 : prev_trk_q;
	assign cur_entries    = first_s1 ? ENTRIES_INIT : entries_q;
	assign cur_prev_valid = first_s1 ? 1'b0 : prev_valid_q;
	assign cur_protect    = first_s1 ? 1'b0 : protect_q;
	assign cur_type       = first_s1 ? '0 : type_q;

	logic             work;
	logic [31:0]      gather_next;
	logic [POS_W-1:0] rel;
	logic [TRK_W-1:0] trk;
	logic             trk_final;
	logic [31:0]      off_raw, off;
	logic             off_small, shorten;
	logic [31:0]      prev_size;

	assign work        = valid_s1 && (first_s1 || !finished_q);
	assign gather_next = {data_s1, cur_gather[31:8]};
	assign rel         = cur_pos - FIXED_POS;
	assign trk         = rel[TRK_W+1:2];
	assign trk_final   = (trk == TRK_LAST);
	assign off_raw     = (trk < cur_entries) ? gather_next : 32'd0;
	assign off         = (off_raw > cur_size) ? 32'd0 : off_raw;
	assign off_small   = (off < cur_rmin);
	assign shorten     = !cur_prev_valid && (off == cur_rmin - SHORTEN_BYTES);
	assign prev_size   = off - cur_rmin;

	logic             fail_en;
	logic [2:0]       fail_kind;
	logic             track_en;
	logic [TRK_W-1:0] track_idx;
	logic [31:0]      track_len;
	logic             finish_en;
	logic [31:0]      finish_len;

	always_comb begin
		pos_d        = pos_q;
		name_term_d  = name_term_q;
		finished_d   = finished_q;
		gather_d     = gather_q;
		size_d       = size_q;
		rmin_d       = rmin_q;
		prev_trk_d   = prev_trk_q;
		prev_valid_d = prev_valid_q;
		entries_d    = entries_q;
		protect_d    = protect_q;
		type_d       = type_q;
		fail_en      = 1'b0;
		fail_kind    = KIND_BAD_OFFSET;
		track_en     = 1'b0;
		track_idx    = '0;
		track_len    = '0;
		finish_en    = 1'b0;
		if (work) begin
			pos_d        = cur_pos + 1'b1;
			name_term_d  = cur_name_term;
			finished_d   = 1'b0;
			gather_d     = cur_gather;
			size_d       = cur_size;
			rmin_d       = cur_rmin;
			prev_trk_d   = cur_prev_trk;
			prev_valid_d = cur_prev_valid;
			entries_d    = cur_entries;
			protect_d    = cur_protect;
			type_d       = cur_type;
			if (cur_pos < PROTECT_POS) begin
				if (data_s1 == 8'd0) begin
					name_term_d = 1'b1;
				end
				if (cur_pos == NAME_LAST_POS && !name_term_d) begin
					fail_en   = 1'b1;
					fail_kind = KIND_NAME_UNTERM;
				end
			end else if (cur_pos == PROTECT_POS) begin
				if (data_s1 != PROTECT_OFF && data_s1 != PROTECT_ON) begin
					fail_en   = 1'b1;
					fail_kind = KIND_BAD_PROTECT;
				end else begin
					protect_d = (data_s1 == PROTECT_ON);
				end
			end else if (cur_pos == TYPE_POS) begin
				type_d = data_s1;
				if (data_s1 != type_a_q && data_s1 != type_b_q && data_s1 != type_c_q) begin
					fail_en   = 1'b1;
					fail_kind = KIND_BAD_TYPE;
				end
			end else begin
				gather_d = gather_next;
				if (cur_pos < FIXED_POS) begin
					if (cur_pos == SIZE_LAST_POS) begin
						size_d = gather_next;
						if (gather_next > max_size_q || gather_next < MIN_SIZE) begin
							fail_en   = 1'b1;
							fail_kind = KIND_BAD_SIZE;
						end
					end
				end else if (rel[1:0] == 2'b11) begin
					// A whole offset table entry has been gathered.
					if (off == 32'd0) begin
						track_en  = 1'b1;
						track_idx = trk;
						finish_en = trk_final;
					end else if (off_small && !shorten) begin
						fail_en   = 1'b1;
						fail_kind = KIND_BAD_OFFSET;
					end else begin
						if (off_small) begin
							entries_d = cur_entries - SHORTEN_TRACKS;
						end
						if (cur_prev_valid) begin
							track_en  = 1'b1;
							track_idx = cur_prev_trk;
							track_len = prev_size;
						end
						prev_trk_d   = trk;
						prev_valid_d = 1'b1;
						rmin_d       = off;
						finish_en    = trk_final;
					end
				end
			end
			if (fail_en || finish_en) begin
				finished_d = 1'b1;
			end
		end
	end

	// The closing record carries the size of the last nonzero track.
	assign finish_len = size_d - rmin_d;

	function automatic result_t make_rec(
		input logic [2:0]       kind,
		input logic [TRK_W-1:0] idx,
		input logic [31:0]      len,
		input logic             last,
		input logic             prot,
		input logic [7:0]       dtype,
		input logic [31:0]      dsize
	);
		result_t r;
		r.kind            = kind;
		r.track_index     = idx;
		r.track_size      = len;
		r.write_protected = prot;
		r.disk_type       = dtype;
		r.disk_size       = dsize;
		r.last            = last;
		return r;
	endfunction

	result_t fail_rec, track_rec, finish_rec;

	assign fail_rec   = make_rec(fail_kind, '0, '0, 1'b1, protect_d, type_d, size_d);
	assign track_rec  = make_rec(KIND_TRACK, track_idx, track_len, 1'b0,
		protect_d, type_d, size_d);
	assign finish_rec = prev_valid_d
		? make_rec(KIND_ACCEPTED, prev_trk_d, finish_len, 1'b1, protect_d, type_d, size_d)
		: make_rec(KIND_ACCEPTED, '0, '0, 1'b1, protect_d, type_d, size_d);

	always_comb begin
		push.count = 2'd0;
		push.rec0  = track_rec;
		push.rec1  = finish_rec;
		if (fail_en) begin
			push.count = 2'd1;
			push.rec0  = fail_rec;
		end else if (track_en) begin
			push.count = finish_en ? 2'd2 : 2'd1;
		end else if (finish_en) begin
			push.count = 2'd1;
			push.rec0  = finish_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= 32'hFFFF_FFFF;
			type_a_q   <= 8'h00;
			type_b_q   <= 8'h10;
			type_c_q   <= 8'h20;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAX_SIZE: max_size_q <= cfg_data;
				REG_TYPE_A:   type_a_q   <= cfg_data[7:0];
				REG_TYPE_B:   type_b_q   <= cfg_data[7:0];
				REG_TYPE_C:   type_c_q   <= cfg_data[7:0];
				default:      max_size_q <= max_size_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			name_term_q  <= 1'b0;
			finished_q   <= 1'b1;
			gather_q     <= '0;
			size_q       <= '0;
			rmin_q       <= MIN_SIZE;
			prev_trk_q   <= '0;
			prev_valid_q <= 1'b0;
			entries_q    <= ENTRIES_INIT;
			protect_q    <= 1'b0;
			type_q       <= '0;
		end else begin
			pos_q        <= pos_d;
			name_term_q  <= name_term_d;
			finished_q   <= finished_d;
			gather_q     <= gather_d;
			size_q       <= size_d;
			rmin_q       <= rmin_d;
			prev_trk_q   <= prev_trk_d;
			prev_valid_q <= prev_valid_d;
			entries_q    <= entries_d;
			protect_q    <= protect_d;
			type_q       <= type_d;
		end
	end

	// Of two words pushed together, only the second can close an image.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.rec1.last && !push.rec0.last)
		else $error("two-word push out of order");

	// Once the closing word is pushed, the parse stops.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd1 && push.rec0.last) || push.count == 2'd2 |=> finished_q)
		else $error("parse continued after its last word");

	// A finished parse ignores bytes until the next first byte.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q && valid_s1 && !first_s1 |-> push.count == 2'd0)
		else $error("word produced while idle");

endmodule

`default_nettype wire

FILE: rtl/core/dihp_result_queue.sv
`default_nettype none

module dihp_result_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  dihp_pkg::push_t     push,
	output logic                room,
	output logic                result_valid,
	input  wire                 result_stall,
	output dihp_pkg::result_t   head
);
	import dihp_pkg::*;

	localparam logic [RQ_PTR_W:0] DEPTH_C = (RQ_PTR_W + 1)'(RQ_DEPTH);
	// Room for two words in flight plus two from a new byte.
	localparam logic [RQ_PTR_W:0] ROOM_LIMIT = (RQ_PTR_W + 1)'(RQ_DEPTH - 4);

	result_t             mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
	logic [RQ_PTR_W:0]   count_q;
	logic                pop;

	assign pop          = result_valid && !result_stall;
	assign result_valid = (count_q != '0);
	assign head         = mem_q[rd_ptr_q];
	assign room         = (count_q <= ROOM_LIMIT);
	assign wr_ptr_1     = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.rec0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_1] <= push.rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(pop);
			count_q  <= count_q + (RQ_PTR_W + 1)'(push.count) - (RQ_PTR_W + 1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q + (RQ_PTR_W + 1)'(push.count) <= DEPTH_C)
		else $error("result queue overflow");

endmodule

`default_nettype wire
